// File: rtl/core/ips_pkg.sv
// Shared types, constants and the case-folding helper function of the incremental prefix search block.
package ips_pkg;

	localparam int ENTRIES       = 32;
	localparam int STRING_LENGTH = 32;
	localparam int ENTRY_W       = $clog2(ENTRIES);
	localparam int POS_W         = $clog2(STRING_LENGTH);
	localparam int DEPTH_W       = $clog2(STRING_LENGTH + 1);
	localparam int ADDR_W        = ENTRY_W + POS_W;
	localparam int TABLE_DEPTH   = ENTRIES * STRING_LENGTH;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [7:0]         char_t;
	typedef logic [2:0]         status_t;
	typedef logic [1:0]         action_t;
	typedef logic [QCNT_W-1:0]  qcnt_t;
	typedef logic [QPTR_W-1:0]  qptr_t;

	localparam action_t ACT_WRITE = 2'd0;
	localparam action_t ACT_START = 2'd1;
	localparam action_t ACT_KEY   = 2'd2;

	localparam char_t KEY_ESCAPE = 8'd27;
	localparam char_t KEY_RETURN = 8'd13;

	localparam status_t ST_NARROWED = 3'd0;
	localparam status_t ST_FINAL    = 3'd1;
	localparam status_t ST_NOMATCH  = 3'd2;
	localparam status_t ST_ABORTED  = 3'd3;
	localparam status_t ST_IGNORED  = 3'd4;

	localparam int CFG_LAST_ENTRY     = 0;
	localparam int CFG_CASE_SENSITIVE = 1;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_START,
		CMD_KEY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		entry_t    entry;
		pos_t      position;
		char_t     ch;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN_RD,
		BK_SCAN_CMP,
		BK_EQ_RA,
		BK_EQ_RB,
		BK_EQ_CHK,
		BK_EMIT
	} back_state_t;

	function automatic char_t fold(input char_t c, input logic case_sensitive);
		char_t r;
		r = c;
		if (!case_sensitive && c >= "a" && c <= "z") begin
			r = c - 8'd32;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/ips_front.sv
// Front end: accepts input beats, classifies them into commands and queues them.
module ips_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ips_pkg::action_t    action,
	input  ips_pkg::entry_t     entry,
	input  ips_pkg::pos_t       position,
	input  ips_pkg::char_t      char_value,
	output logic                q_valid,
	input  logic                q_ready,
	output ips_pkg::cmd_t       q_cmd
);

	ips_pkg::cmd_t queue_q [ips_pkg::QUEUE_DEPTH];
	ips_pkg::qptr_t wr_ptr_q;
	ips_pkg::qptr_t rd_ptr_q;
	ips_pkg::qcnt_t count_q;
	ips_pkg::cmd_t cls_cmd;
	logic is_cmd;
	logic push;
	logic pop;

	always_comb begin
		cls_cmd.kind     = ips_pkg::CMD_WRITE;
		cls_cmd.entry    = entry;
		cls_cmd.position = position;
		cls_cmd.ch       = char_value;
		is_cmd           = 1'b1;
		unique case (action)
			ips_pkg::ACT_WRITE: cls_cmd.kind = ips_pkg::CMD_WRITE;
			ips_pkg::ACT_START: cls_cmd.kind = ips_pkg::CMD_START;
			ips_pkg::ACT_KEY:   cls_cmd.kind = ips_pkg::CMD_KEY;
			default:            is_cmd = 1'b0;
		endcase
	end

	assign cmd_ready = (count_q != ips_pkg::qcnt_t'(ips_pkg::QUEUE_DEPTH));
	assign push      = cmd_valid && cmd_ready && is_cmd;
	assign q_valid   = (count_q != '0);
	assign q_cmd     = queue_q[rd_ptr_q];
	assign pop       = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ips_pkg::qptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ips_pkg::qptr_t'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ips_pkg::qcnt_t'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ips_pkg::qcnt_t'(1);
			end
		end
	end

endmodule

// File: rtl/core/ips_back.sv
// Back end: string table memory, search sequencer and result register.
module ips_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  ips_pkg::cmd_t     q_cmd,
	input  ips_pkg::entry_t   last_entry,
	input  logic              case_sensitive,
	output logic              res_valid,
	input  logic              res_ready,
	output ips_pkg::status_t  status,
	output ips_pkg::entry_t   first_index,
	output ips_pkg::entry_t   end_index
);

	ips_pkg::char_t mem [ips_pkg::TABLE_DEPTH];
	ips_pkg::char_t rdata_q;
	ips_pkg::addr_t rd_addr;

	ips_pkg::back_state_t state_q;
	ips_pkg::back_state_t state_d;

	ips_pkg::entry_t range_first_q;
	ips_pkg::entry_t range_last_q;
	ips_pkg::depth_t depth_q;
	logic            active_q;
	ips_pkg::char_t  key_q;
	ips_pkg::entry_t j_q;
	logic            found_q;
	ips_pkg::entry_t lo_q;
	ips_pkg::entry_t hi_q;
	ips_pkg::pos_t   d_q;
	ips_pkg::char_t  ca_q;
	ips_pkg::status_t status_q;

	logic            res_valid_q;
	ips_pkg::status_t res_status_q;
	ips_pkg::entry_t res_first_q;
	ips_pkg::entry_t res_last_q;

	logic            take;
	logic            past_end;
	ips_pkg::char_t  scan_ch;
	logic            hit;
	logic            stop;
	logic            found_next;
	ips_pkg::entry_t lo_next;
	ips_pkg::entry_t hi_next;
	logic            out_free;
	logic            key_direct;
	ips_pkg::entry_t last_sat;

	assign take       = (state_q == ips_pkg::BK_IDLE) && q_valid;
	assign past_end   = (depth_q >= ips_pkg::depth_t'(ips_pkg::STRING_LENGTH));
	assign scan_ch    = past_end ? '0 : rdata_q;
	assign hit        = (ips_pkg::fold(scan_ch, case_sensitive) == key_q);
	assign stop       = (found_q && !hit) || (j_q == range_last_q);
	assign found_next = found_q || hit;
	assign lo_next    = found_q ? lo_q : j_q;
	assign hi_next    = (found_q && !hit) ? hi_q : j_q;
	assign out_free   = !res_valid_q || res_ready;
	assign key_direct = !active_q || (q_cmd.ch == ips_pkg::KEY_ESCAPE)
		|| (q_cmd.ch == ips_pkg::KEY_RETURN);
	assign last_sat   = (last_entry > ips_pkg::entry_t'(ips_pkg::ENTRIES - 1))
		? ips_pkg::entry_t'(ips_pkg::ENTRIES - 1) : last_entry;

	assign res_valid   = res_valid_q;
	assign status      = res_status_q;
	assign first_index = res_first_q;
	assign end_index   = res_last_q;

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		rd_addr = {j_q, depth_q[ips_pkg::POS_W-1:0]};
		unique case (state_q)
			ips_pkg::BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid && q_cmd.kind == ips_pkg::CMD_KEY) begin
					state_d = key_direct ? ips_pkg::BK_EMIT : ips_pkg::BK_SCAN_RD;
				end
			end
			ips_pkg::BK_SCAN_RD: begin
				state_d = ips_pkg::BK_SCAN_CMP;
			end
			ips_pkg::BK_SCAN_CMP: begin
				if (stop) begin
					state_d = found_next ? ips_pkg::BK_EQ_RA : ips_pkg::BK_EMIT;
				end else begin
					state_d = ips_pkg::BK_SCAN_RD;
				end
			end
			ips_pkg::BK_EQ_RA: begin
				rd_addr = {lo_q, d_q};
				state_d = ips_pkg::BK_EQ_RB;
			end
			ips_pkg::BK_EQ_RB: begin
				rd_addr = {hi_q, d_q};
				state_d = ips_pkg::BK_EQ_CHK;
			end
			ips_pkg::BK_EQ_CHK: begin
				if (ca_q != rdata_q || ca_q == '0
					|| d_q == ips_pkg::pos_t'(ips_pkg::STRING_LENGTH - 1)) begin
					state_d = ips_pkg::BK_EMIT;
				end else begin
					state_d = ips_pkg::BK_EQ_RA;
				end
			end
			ips_pkg::BK_EMIT: begin
				if (out_free) begin
					state_d = ips_pkg::BK_IDLE;
				end
			end
			default: state_d = ips_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ips_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_cmd.kind == ips_pkg::CMD_WRITE) begin
			mem[{q_cmd.entry, q_cmd.position}] <= q_cmd.ch;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= '0;
			range_last_q  <= '0;
			depth_q       <= '0;
			active_q      <= 1'b0;
			key_q         <= '0;
			j_q           <= '0;
			found_q       <= 1'b0;
			lo_q          <= '0;
			hi_q          <= '0;
			d_q           <= '0;
			ca_q          <= '0;
			status_q      <= ips_pkg::ST_IGNORED;
			res_valid_q   <= 1'b0;
			res_status_q  <= ips_pkg::ST_IGNORED;
			res_first_q   <= '0;
			res_last_q    <= '0;
		end else begin
			if (state_q == ips_pkg::BK_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ips_pkg::BK_IDLE: begin
					if (q_valid && q_cmd.kind == ips_pkg::CMD_START) begin
						range_first_q <= '0;
						range_last_q  <= last_sat;
						depth_q       <= '0;
						active_q      <= 1'b1;
					end else if (q_valid && q_cmd.kind == ips_pkg::CMD_KEY) begin
						key_q   <= ips_pkg::fold(q_cmd.ch, case_sensitive);
						j_q     <= range_first_q;
						found_q <= 1'b0;
						if (!active_q) begin
							status_q <= ips_pkg::ST_IGNORED;
						end else if (q_cmd.ch == ips_pkg::KEY_ESCAPE) begin
							status_q <= ips_pkg::ST_ABORTED;
							active_q <= 1'b0;
						end else if (q_cmd.ch == ips_pkg::KEY_RETURN) begin
							status_q <= ips_pkg::ST_FINAL;
							active_q <= 1'b0;
						end
					end
				end
				ips_pkg::BK_SCAN_CMP: begin
					found_q <= found_next;
					lo_q    <= lo_next;
					hi_q    <= hi_next;
					j_q     <= j_q + ips_pkg::entry_t'(1);
					if (stop) begin
						if (found_next) begin
							range_first_q <= lo_next;
							range_last_q  <= hi_next;
							d_q           <= '0;
							if (!past_end) begin
								depth_q <= depth_q + ips_pkg::depth_t'(1);
							end
						end else begin
							status_q <= ips_pkg::ST_NOMATCH;
							active_q <= 1'b0;
						end
					end
				end
				ips_pkg::BK_EQ_RB: begin
					ca_q <= rdata_q;
				end
				ips_pkg::BK_EQ_CHK: begin
					if (ca_q != rdata_q) begin
						status_q <= ips_pkg::ST_NARROWED;
					end else if (ca_q == '0
						|| d_q == ips_pkg::pos_t'(ips_pkg::STRING_LENGTH - 1)) begin
						status_q <= ips_pkg::ST_FINAL;
						active_q <= 1'b0;
					end else begin
						d_q <= d_q + ips_pkg::pos_t'(1);
					end
				end
				ips_pkg::BK_EMIT: begin
					if (out_free) begin
						res_status_q <= status_q;
						res_first_q  <= range_first_q;
						res_last_q   <= range_last_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/incremental_prefix_search.sv
// Top level of the incremental prefix search block: configuration registers and the two halves.
//
// Input channel (cmd_valid/cmd_ready) carries one beat per table write, search start
// or typed key; action 3 beats are accepted and dropped. Result channel
// (res_valid/res_ready) carries one beat per typed key: status and the current range.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data): index 0 is the
// last entry searched, index 1 the case-sensitive flag. Write only while idle.
// A two-entry command queue sits between the front end and the sequencer, so beats are
// accepted while a result waits in the output register.
// Writes and starts are handled in the idle state. A key that is ignored, escaped or
// returned goes straight to the emit state. A searching key reads and compares each entry
// scanned (one table read, one compare), then, when a match was found, compares the
// end-of-range strings character by character (read low entry, read high entry, check);
// the string table has a single read port.
// Reset clears the range, depth, open search, configuration and all valid flags; the
// table is not cleared and must be written before it is searched.
// When res_ready is low and the output register is full, the sequencer holds its finished
// result and stops; the queue then fills and cmd_ready drops.
module incremental_prefix_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ips_pkg::action_t    action,
	input  ips_pkg::entry_t     entry,
	input  ips_pkg::pos_t       position,
	input  ips_pkg::char_t      char_value,
	output logic                res_valid,
	input  logic                res_ready,
	output ips_pkg::status_t    status,
	output ips_pkg::entry_t     first_index,
	output ips_pkg::entry_t     end_index,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data
);

	ips_pkg::entry_t last_entry_q;
	logic            case_sensitive_q;
	logic            q_valid;
	logic            q_ready;
	ips_pkg::cmd_t   q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_entry_q     <= '0;
			case_sensitive_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == 1'(ips_pkg::CFG_LAST_ENTRY)) begin
				last_entry_q <= cfg_data[ips_pkg::ENTRY_W-1:0];
			end else if (cfg_index == 1'(ips_pkg::CFG_CASE_SENSITIVE)) begin
				case_sensitive_q <= cfg_data[0];
			end
		end
	end

	ips_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.action     (action),
		.entry      (entry),
		.position   (position),
		.char_value (char_value),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_cmd      (q_cmd)
	);

	ips_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_cmd          (q_cmd),
		.last_entry     (last_entry_q),
		.case_sensitive (case_sensitive_q),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.status         (status),
		.first_index    (first_index),
		.end_index      (end_index)
	);

endmodule

// File: tb/ips_search_checker.sv
// Checker for the incremental prefix search block: predicts every result beat and compares it.
module ips_search_checker
	import ips_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_ready,
	input  action_t    action,
	input  entry_t     entry,
	input  pos_t       position,
	input  char_t      char_value,
	input  logic       res_valid,
	input  logic       res_ready,
	input  status_t    status,
	input  entry_t     first_index,
	input  entry_t     end_index,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_data,
	output int         fail_count,
	output int         ranges_pending,
	output int         results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t code;
		entry_t  lo;
		entry_t  hi;
	} range_report_t;

	char_t         text_store [TABLE_DEPTH];
	entry_t        span_lo = '0;
	entry_t        span_hi = '0;
	depth_t        depth = '0;
	logic          searching = 1'b0;
	entry_t        sel_last = '0;
	logic          sel_exact = 1'b0;
	range_report_t expected_ranges [$];
	int            fails = 0;
	int            results = 0;
	int            pending = 0;

	assign fail_count     = fails;
	assign results_seen   = results;
	assign ranges_pending = pending;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			text_store[i] = 8'd0;
		end
	end

	function automatic char_t entry_char(entry_t e, int d);
		if (d >= STRING_LENGTH) begin
			return 8'd0;
		end
		return text_store[int'(e) * STRING_LENGTH + d];
	endfunction

	function automatic char_t fold_case(char_t c);
		if (!sel_exact && c >= "a" && c <= "z") begin
			return c - 8'd32;
		end
		return c;
	endfunction

	function automatic logic entries_identical(entry_t a, entry_t b);
		char_t ca;
		for (int d = 0; d < STRING_LENGTH; d++) begin
			ca = entry_char(a, d);
			if (ca != entry_char(b, d)) begin
				return 1'b0;
			end
			if (ca == 8'd0) begin
				return 1'b1;
			end
		end
		return 1'b1;
	endfunction

	function automatic void note_result(status_t code);
		expected_ranges.push_back('{code, span_lo, span_hi});
	endfunction

	task automatic advance_search(action_t act, entry_t ent, pos_t pos, char_t ch);
		char_t  key;
		logic   found;
		logic   hit;
		entry_t lo;
		entry_t hi;
		if (act == ACT_WRITE) begin
			text_store[int'(ent) * STRING_LENGTH + int'(pos)] = ch;
		end else if (act == ACT_START) begin
			span_lo   = '0;
			span_hi   = (int'(sel_last) < ENTRIES) ? sel_last : entry_t'(ENTRIES - 1);
			depth     = '0;
			searching = 1'b1;
		end else if (act == ACT_KEY) begin
			if (!searching) begin
				note_result(ST_IGNORED);
			end else if (ch == KEY_ESCAPE) begin
				searching = 1'b0;
				note_result(ST_ABORTED);
			end else if (ch == KEY_RETURN) begin
				searching = 1'b0;
				note_result(ST_FINAL);
			end else begin
				key   = fold_case(ch);
				found = 1'b0;
				lo    = '0;
				hi    = '0;
				for (int j = int'(span_lo); j <= int'(span_hi); j++) begin
					hit = (fold_case(entry_char(entry_t'(j), int'(depth))) == key);
					if (!found && hit) begin
						found = 1'b1;
						lo    = entry_t'(j);
						hi    = entry_t'(j);
					end else if (found) begin
						if (!hit) begin
							break;
						end
						hi = entry_t'(j);
					end
				end
				if (!found) begin
					searching = 1'b0;
					note_result(ST_NOMATCH);
				end else begin
					span_lo = lo;
					span_hi = hi;
					if (int'(depth) < STRING_LENGTH) begin
						depth = depth + 1'b1;
					end
					if (entries_identical(lo, hi)) begin
						searching = 1'b0;
						note_result(ST_FINAL);
					end else begin
						note_result(ST_NARROWED);
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		range_report_t got;
		range_report_t want;
		if (!arst_n) begin
			span_lo   = '0;
			span_hi   = '0;
			depth     = '0;
			searching = 1'b0;
			sel_last  = '0;
			sel_exact = 1'b0;
			expected_ranges.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(CFG_LAST_ENTRY)) begin
					sel_last = cfg_data;
				end else begin
					sel_exact = cfg_data[0];
				end
			end
			if (res_valid && res_ready) begin
				results++;
				got = '{status, first_index, end_index};
				if (expected_ranges.size() == 0) begin
					if (fails < 10) begin
						$display("Unexpected result beat: status %0d range %0d..%0d",
							status, first_index, end_index);
					end
					fails++;
				end else begin
					want = expected_ranges.pop_front();
					if (got !== want) begin
						if (fails < 10) begin
							$display({"Result %0d mismatch: expected status %0d range ",
								"%0d..%0d, got status %0d range %0d..%0d"},
								results, want.code, want.lo, want.hi,
								got.code, got.lo, got.hi);
						end
						fails++;
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				advance_search(action, entry, position, char_value);
			end
		end
		pending = expected_ranges.size();
	end

endmodule

// File: tb/incremental_prefix_search_tb.sv
// Testbench top for the incremental prefix search block: stimulus, backpressure and verdict.
module incremental_prefix_search_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ips_pkg::*;

	localparam action_t ACT_UNUSED    = 2'd3;
	localparam int      SETTLE_CYCLES = 200;
	localparam int      CYCLE_LIMIT   = 1_200_000;
	localparam int      PHASES        = 6;
	localparam int      PHASE_ITEMS [PHASES] = '{275, 275, 175, 275, 325, 325};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	action_t    action = ACT_WRITE;
	entry_t     entry = '0;
	pos_t       position = '0;
	char_t      char_value = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	status_t    status;
	entry_t     first_index;
	entry_t     end_index;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [4:0] cfg_data = '0;
	int         fail_count;
	int         ranges_pending;
	int         results_seen;

	char_t      tbl_img [ENTRIES][STRING_LENGTH];
	int         cur_last = 0;
	logic       cur_cs = 1'b0;
	int         burst_left = 0;
	int         items_sent = 0;
	int         sessions = 0;
	int         cycle_count = 0;
	int         stall_mode = 0;
	int         stall_left = 0;

	incremental_prefix_search u_top (.*);
	ips_search_checker u_checker (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out with %0d results still expected.", ranges_pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: begin
				res_ready <= 1'b1;
			end
			1: begin
				res_ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				res_ready <= ($urandom_range(0, 9) != 0);
			end
			default: begin
				res_ready <= ((stall_left % 16) < 4);
			end
		endcase
	end

	task automatic send_beat(action_t a, entry_t e, pos_t p, char_t c);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd_valid  <= 1'b1;
		action     <= a;
		entry      <= e;
		position   <= p;
		char_value <= c;
		if (a != ACT_UNUSED) begin
			items_sent++;
		end
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	task automatic send_key(char_t c);
		send_beat(ACT_KEY, entry_t'($urandom), pos_t'($urandom), c);
	endtask

	task automatic send_start();
		send_beat(ACT_START, entry_t'($urandom), pos_t'($urandom), char_t'($urandom));
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (ranges_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(entry_t last_sel, logic cs);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= 1'(CFG_LAST_ENTRY);
		cfg_data  <= last_sel;
		@(negedge clk);
		cfg_index <= 1'(CFG_CASE_SENSITIVE);
		cfg_data  <= {4'($urandom), cs};
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_last = int'(last_sel);
		cur_cs   = cs;
	endtask

	task automatic load_table();
		for (int e = 0; e < ENTRIES; e++) begin
			for (int p = 0; p < STRING_LENGTH; p++) begin
				send_beat(ACT_WRITE, entry_t'(e), pos_t'(p), tbl_img[e][p]);
			end
		end
	endtask

	function automatic void put_text(int e, string s);
		for (int p = 0; p < STRING_LENGTH; p++) begin
			tbl_img[e][p] = (p < s.len()) ? char_t'(s[p]) : 8'd0;
		end
	endfunction

	function automatic void build_directed_table();
		put_text(0, "");
		put_text(1, "APPLE");
		put_text(2, "APPLY");
		put_text(3, "APRIL");
		put_text(4, "BANANA");
		put_text(5, "BANANA");
		put_text(6, "Berry");
		for (int p = 0; p < STRING_LENGTH; p++) begin
			tbl_img[7][p] = (p < STRING_LENGTH - 1) ? "X" : "A";
			tbl_img[8][p] = (p < STRING_LENGTH - 1) ? "X" : "B";
		end
		for (int e = 9; e < ENTRIES; e++) begin
			put_text(e, "Z");
			tbl_img[e][1] = char_t'("A" + e - 9);
		end
	endfunction

	function automatic char_t pick_char();
		if ($urandom_range(0, 4) == 0) begin
			return char_t'($urandom_range(1, 255));
		end
		return char_t'("A" + $urandom_range(0, 2) + ($urandom_range(0, 1) ? 32 : 0));
	endfunction

	function automatic logic row_before(int a, int b);
		for (int d = 0; d < STRING_LENGTH; d++) begin
			if (tbl_img[a][d] != tbl_img[b][d]) begin
				return tbl_img[a][d] < tbl_img[b][d];
			end
		end
		return 1'b0;
	endfunction

	function automatic void make_random_table();
		char_t row_tmp [STRING_LENGTH];
		int    len;
		int    keep;
		for (int e = 0; e < ENTRIES; e++) begin
			for (int p = 0; p < STRING_LENGTH; p++) begin
				tbl_img[e][p] = 8'd0;
			end
			case ($urandom_range(0, 9))
				0: begin
				end
				1: begin
					if (e > 0) begin
						tbl_img[e] = tbl_img[e-1];
					end
				end
				2: begin
					keep = $urandom_range(20, STRING_LENGTH - 1);
					for (int p = 0; p < STRING_LENGTH; p++) begin
						tbl_img[e][p] = (e > 0 && p < keep) ? tbl_img[e-1][p] : pick_char();
					end
				end
				default: begin
					len = $urandom_range(1, 6);
					for (int p = 0; p < len; p++) begin
						tbl_img[e][p] = pick_char();
					end
				end
			endcase
		end
		for (int i = 1; i < ENTRIES; i++) begin
			for (int j = i; j > 0 && row_before(j, j - 1); j--) begin
				row_tmp        = tbl_img[j];
				tbl_img[j]     = tbl_img[j - 1];
				tbl_img[j - 1] = row_tmp;
			end
		end
	endfunction

	function automatic int text_len(int e);
		for (int p = 0; p < STRING_LENGTH; p++) begin
			if (tbl_img[e][p] == 8'd0) begin
				return p;
			end
		end
		return STRING_LENGTH;
	endfunction

	task automatic run_directed();
		send_key("a");
		send_start();
		send_key("a");
		send_key("P");
		send_key("p");
		send_key("l");
		send_key("E");
		send_start();
		send_key(KEY_ESCAPE);
		send_start();
		send_key(KEY_RETURN);
		send_start();
		send_key("q");
		send_start();
		send_key("b");
		send_start();
		send_key(8'd0);
		send_start();
		send_key("B");
		send_key("a");
		send_beat(ACT_UNUSED, '1, '1, '1);
		send_key("x");
		send_start();
		send_key(8'hFF);
	endtask

	task automatic run_session();
		int    tgt;
		int    len;
		int    nkeys;
		char_t c;
		sessions++;
		send_start();
		tgt   = $urandom_range(0, cur_last);
		len   = text_len(tgt);
		nkeys = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len + 1) : len + 1;
		for (int d = 0; d < nkeys; d++) begin
			c = (d < STRING_LENGTH) ? tbl_img[tgt][d] : 8'd0;
			if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
					&& $urandom_range(0, 99) < (cur_cs ? 10 : 35)) begin
				c ^= 8'h20;
			end else if ($urandom_range(0, 39) == 0) begin
				c = char_t'($urandom_range(0, 255));
			end
			send_key(c);
		end
		case ($urandom_range(0, 5))
			0, 1: begin
				send_key(KEY_RETURN);
			end
			2: begin
				send_key(KEY_ESCAPE);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_noise();
		entry_t e;
		pos_t   p;
		char_t  c;
		e = entry_t'($urandom);
		p = pos_t'($urandom);
		c = char_t'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				tbl_img[e][p] = c;
				send_beat(ACT_WRITE, e, p, c);
			end
			1: begin
				send_beat(ACT_KEY, e, p, c);
			end
			2: begin
				send_beat(ACT_START, e, p, c);
			end
			3: begin
				send_beat(ACT_UNUSED, e, p, c);
			end
			4: begin
				send_key($urandom_range(0, 1) ? KEY_ESCAPE : KEY_RETURN);
			end
			default: begin
				send_key(char_t'("a" + $urandom_range(0, 25)));
			end
		endcase
	endtask

	initial begin
		int base;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_and_settle();
			case (ph)
				0: begin
					write_config(5'd31, 1'b0);
					build_directed_table();
					load_table();
					run_directed();
				end
				1: begin
					write_config(5'd31, 1'b1);
					make_random_table();
					load_table();
				end
				2: begin
					write_config(5'd0, 1'b0);
				end
				3: begin
					write_config(entry_t'($urandom_range(1, 30)), 1'b1);
				end
				4: begin
					write_config(5'd31, 1'b0);
					make_random_table();
					load_table();
				end
				default: begin
					write_config(entry_t'($urandom), 1'($urandom));
				end
			endcase
			base = items_sent;
			while (items_sent - base < PHASE_ITEMS[ph]) begin
				if ($urandom_range(0, 4) == 0) begin
					send_noise();
				end else begin
					run_session();
				end
			end
		end
		drain_and_settle();
		$display("Sent %0d command beats, %0d search sessions, over %0d register settings.",
			items_sent, sessions, PHASES);
		$display("Compared %0d result beats; %0d failed.", results_seen, fail_count);
		if (fail_count == 0 && ranges_pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
